/* rtl/swm_pkg.sv */
`default_nettype none
package swm_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 32;
    localparam int CFG_W       = 7;
    localparam int OUT_W       = SAMPLE_BITS + 1;
    localparam int IDX_W       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
    localparam int TAP_GROUP   = 8;
    localparam int TAP_GROUPS  = (MAX_WINDOW + TAP_GROUP - 1) / TAP_GROUP;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(3);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    // What a cell shows its neighbors in every cycle.
    typedef struct packed {
        t_sample          val;
        logic [IDX_W-1:0] age;
        logic             le;
        logic             adel;
    } t_link;

    // Broadcast from the top level to every cell.
    typedef struct packed {
        t_sample          sample;
        logic             ins;
        logic             full;
        logic [IDX_W-1:0] del_idx;
        logic [CNT_W-1:0] count;
        logic [IDX_W-1:0] lo_idx;
        logic [IDX_W-1:0] hi_idx;
        logic [IDX_W-1:0] win_m1;
    } t_ctrl;

    // A size of zero means one sample; sizes above the chain length saturate.
    function automatic logic [CNT_W-1:0] eff_window(input logic [CFG_W-1:0] v);
        logic [CNT_W-1:0] res;
        if (v == '0) begin
            res = CNT_W'(1);
        end else if (int'(v) > MAX_WINDOW) begin
            res = CNT_W'(MAX_WINDOW);
        end else begin
            res = CNT_W'(v);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

/* rtl/swm_sample_if.sv */
`default_nettype none
interface swm_sample_if;
    logic                 valid;
    logic                 ready;
    swm_pkg::t_sample     sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

/* rtl/swm_result_if.sv */
`default_nettype none
interface swm_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [swm_pkg::OUT_W-1:0]    median_doubled;

    modport source (output valid, output median_doubled, input ready);
    modport sink   (input valid, input median_doubled, output ready);
endinterface
`default_nettype wire

/* rtl/swm_cfg_if.sv */
`default_nettype none
interface swm_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [swm_pkg::CFG_W-1:0]    window_size;

    modport source (output valid, output window_size, input ready);
    modport sink   (input valid, input window_size, output ready);
endinterface
`default_nettype wire

/* rtl/swm_cell.sv */
`default_nettype none
module swm_cell (
    input  wire logic                        i_clk,
    input  wire logic [swm_pkg::IDX_W-1:0]   i_index,
    input  wire swm_pkg::t_ctrl              i_ctrl,
    input  wire swm_pkg::t_link              i_prev,
    input  wire swm_pkg::t_link              i_next,
    output swm_pkg::t_link                   o_link,
    output logic                             o_del,
    output swm_pkg::t_sample                 o_lo,
    output swm_pkg::t_sample                 o_hi
);

    swm_pkg::t_sample              r_val;
    swm_pkg::t_sample              n_val;
    logic [swm_pkg::IDX_W-1:0]     r_age;
    logic [swm_pkg::IDX_W-1:0]     n_age;
    logic                          valid;
    logic                          le;
    logic                          adel;
    logic                          cur_le;
    logic                          prev_le;

    assign valid = swm_pkg::CNT_W'(i_index) < i_ctrl.count;
    assign le    = valid && !(r_val > i_ctrl.sample);
    assign adel  = i_ctrl.full && (i_index >= i_ctrl.del_idx);
    assign o_del = i_ctrl.full && valid && (r_age == i_ctrl.win_m1);

    assign o_link = '{val: r_val, age: r_age, le: le, adel: adel};
    assign o_lo   = (i_index == i_ctrl.lo_idx) ? r_val : '0;
    assign o_hi   = (i_index == i_ctrl.hi_idx) ? r_val : '0;

    // Cells at or above the evicted one see the chain shifted down by one;
    // the new sample then goes in front of the first larger survivor.
    assign cur_le  = adel ? i_next.le : le;
    assign prev_le = i_prev.adel ? le : i_prev.le;

    always_comb begin
        if (cur_le) begin
            n_val = adel ? i_next.val : r_val;
            n_age = (adel ? i_next.age : r_age) + 1'b1;
        end else if ((i_index == '0) || prev_le) begin
            n_val = i_ctrl.sample;
            n_age = '0;
        end else begin
            n_val = i_prev.adel ? r_val : i_prev.val;
            n_age = (i_prev.adel ? r_age : i_prev.age) + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins) begin
            r_val <= n_val;
            r_age <= n_age;
        end
    end

endmodule
`default_nettype wire

/* rtl/swm_tap_tree.sv */
`default_nettype none
module swm_tap_tree (
    input  wire logic                             i_clk,
    input  wire logic                             i_load,
    input  wire swm_pkg::t_sample                 i_lo [swm_pkg::MAX_WINDOW],
    input  wire swm_pkg::t_sample                 i_hi [swm_pkg::MAX_WINDOW],
    output logic signed [swm_pkg::OUT_W-1:0]      o_sum
);

    swm_pkg::t_sample r_lo [swm_pkg::TAP_GROUPS];
    swm_pkg::t_sample r_hi [swm_pkg::TAP_GROUPS];
    swm_pkg::t_sample n_lo [swm_pkg::TAP_GROUPS];
    swm_pkg::t_sample n_hi [swm_pkg::TAP_GROUPS];
    swm_pkg::t_sample lo_all;
    swm_pkg::t_sample hi_all;

    // Only one cell drives each tap, so an OR collects it.
    always_comb begin
        for (int g = 0; g < swm_pkg::TAP_GROUPS; g++) begin
            n_lo[g] = '0;
            n_hi[g] = '0;
            for (int k = 0; k < swm_pkg::TAP_GROUP; k++) begin
                if (g * swm_pkg::TAP_GROUP + k < swm_pkg::MAX_WINDOW) begin
                    n_lo[g] = n_lo[g] | i_lo[g * swm_pkg::TAP_GROUP + k];
                    n_hi[g] = n_hi[g] | i_hi[g * swm_pkg::TAP_GROUP + k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
    end

    always_comb begin
        lo_all = '0;
        hi_all = '0;
        for (int g = 0; g < swm_pkg::TAP_GROUPS; g++) begin
            lo_all = lo_all | r_lo[g];
            hi_all = hi_all | r_hi[g];
        end
    end

    assign o_sum = swm_pkg::OUT_W'(lo_all) + swm_pkg::OUT_W'(hi_all);

endmodule
`default_nettype wire

/* rtl/sliding_window_median.sv */
// Running median over the last W signed samples, W set by the window_size
// register (0 acts as 1, values above 64 act as 64). Samples live in a sorted
// chain of 64 cells; each accepted beat inserts the new sample and, once the
// window is full, drops the oldest one in the same clock. Once W samples are
// held, every sample yields one result, the sum of the two middle values
// (twice the median): the middle taps are registered in the tap tree, then
// summed into the output register once it is free; the input stays stalled
// until then, so the rate is one sample per clock only while filling.
// Writing window_size empties the window.
`default_nettype none
module sliding_window_median (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    swm_sample_if.sink      i_sample,
    swm_result_if.source    o_result,
    swm_cfg_if.sink         i_cfg
);

    logic [swm_pkg::CFG_W-1:0]              r_window;
    logic [swm_pkg::CNT_W-1:0]              r_count;
    logic                                   r_st1;
    logic                                   r_st2;
    logic                                   r_out_valid;
    logic signed [swm_pkg::OUT_W-1:0]       r_out_data;

    logic [swm_pkg::CNT_W-1:0]              win;
    logic                                   full;
    logic                                   accept;
    logic                                   emit;
    logic                                   fire;
    logic [swm_pkg::IDX_W-1:0]              del_idx;
    logic [swm_pkg::MAX_WINDOW-1:0]         del;
    logic signed [swm_pkg::OUT_W-1:0]       sum;
    swm_pkg::t_ctrl                         ctrl;
    swm_pkg::t_link                         link  [swm_pkg::MAX_WINDOW];
    swm_pkg::t_link                         prev  [swm_pkg::MAX_WINDOW];
    swm_pkg::t_link                         next  [swm_pkg::MAX_WINDOW];
    swm_pkg::t_sample                       tap_lo [swm_pkg::MAX_WINDOW];
    swm_pkg::t_sample                       tap_hi [swm_pkg::MAX_WINDOW];

    assign win    = swm_pkg::eff_window(r_window);
    assign full   = (r_count == win);
    assign accept = i_sample.valid && i_sample.ready;
    assign emit   = full || (r_count + 1'b1 == win);
    assign fire   = r_st2 && (!r_out_valid || o_result.ready);

    assign i_sample.ready        = !r_st1 && !r_st2;
    assign i_cfg.ready           = 1'b1;
    assign o_result.valid        = r_out_valid;
    assign o_result.median_doubled = r_out_data;

    always_comb begin
        del_idx = '0;
        for (int i = 0; i < swm_pkg::MAX_WINDOW; i++) begin
            if (del[i]) begin
                del_idx = del_idx | swm_pkg::IDX_W'(i);
            end
        end
    end

    assign ctrl = '{
        sample:  i_sample.sample,
        ins:     accept,
        full:    full,
        del_idx: del_idx,
        count:   r_count,
        lo_idx:  swm_pkg::IDX_W'((win - 1'b1) >> 1),
        hi_idx:  swm_pkg::IDX_W'(win >> 1),
        win_m1:  swm_pkg::IDX_W'(win - 1'b1)
    };

    for (genvar g = 0; g < swm_pkg::MAX_WINDOW; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign prev[g] = '0;
        end else begin : g_mid
            assign prev[g] = link[g-1];
        end
        if (g == swm_pkg::MAX_WINDOW - 1) begin : g_last
            assign next[g] = '0;
        end else begin : g_inner
            assign next[g] = link[g+1];
        end

        swm_cell u_cell (
            .i_clk   (i_clk),
            .i_index (swm_pkg::IDX_W'(g)),
            .i_ctrl  (ctrl),
            .i_prev  (prev[g]),
            .i_next  (next[g]),
            .o_link  (link[g]),
            .o_del   (del[g]),
            .o_lo    (tap_lo[g]),
            .o_hi    (tap_hi[g])
        );
    end

    swm_tap_tree u_tap_tree (
        .i_clk  (i_clk),
        .i_load (r_st1),
        .i_lo   (tap_lo),
        .i_hi   (tap_hi),
        .o_sum  (sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= swm_pkg::CFG_RESET;
            r_count     <= '0;
            r_st1       <= 1'b0;
            r_st2       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_window <= i_cfg.window_size;
                r_count  <= '0;
            end else if (accept && !full) begin
                r_count <= r_count + 1'b1;
            end

            r_st1 <= accept && emit;
            if (r_st1) begin
                r_st2 <= 1'b1;
            end else if (fire) begin
                r_st2 <= 1'b0;
            end

            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= sum;
        end
    end

endmodule
`default_nettype wire

/* rtl/swm_chk.sv */
`default_nettype none
module swm_chk (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_in_valid,
    input wire logic                             i_in_ready,
    input wire logic                             i_out_valid,
    input wire logic                             i_out_ready,
    input wire logic signed [swm_pkg::OUT_W-1:0] i_out_data
);

    // A result beat that is not taken stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result beat changed while stalled");

    // A fresh result is first shown once the sample beat that produced it has gone through r_st1 and r_st2.
    a_out_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 3))
        else $error("result appeared without a matching sample");

    // The input only stalls right after a sample beat.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_in_ready) |-> $past(i_in_valid && i_in_ready))
        else $error("input stalled without a preceding sample");

endmodule

bind sliding_window_median swm_chk u_swm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_data  (o_result.median_doubled)
);
`default_nettype wire
